[rtl/safi_pkg.sv]
// Package for the sprite animation frame index block.
// Holds field widths, fixed-point constants, register indexes and the offset saturation helper.
// No dependencies.
package safi_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int MAX_FRAMES = 4096;

    localparam int FC_W     = 13;
    localparam int RATE_W   = 24;
    localparam int DELAY_W  = 28;
    localparam int STEP_W   = 31;
    localparam int RND_W    = 16;
    localparam int FRAME_W  = 30;
    localparam int START_W  = 32;
    localparam int PAUSE_W  = 16;
    localparam int CSTEP_W  = STEP_W + 1;
    localparam int OFF_W    = 48;
    localparam int LAST_W   = $clog2(MAX_FRAMES) + FRAC_BITS;
    localparam int FPOS_W   = LAST_W + 1;
    localparam int CYC_W    = FPOS_W + 1;
    localparam int PROD_W   = STEP_W + RATE_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int DIV_W    = PROD_W + 1;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int CNT_W    = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_RATE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_FRAMES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REWIND_MODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RANDOM_START  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_START_AT_ZERO = 3'd7;

    typedef logic signed [OFF_W-1:0] offset_t;
    typedef logic signed [SUM_W-1:0] wide_t;

    // Clamp a wide signed value to the signed offset range.
    function automatic offset_t sat_off(input wide_t v);
        offset_t r;
        if (v[SUM_W-1:OFF_W-1] == '0 || v[SUM_W-1:OFF_W-1] == '1)
        begin
            r = v[OFF_W-1:0];
        end
        else if (v[SUM_W-1])
        begin
            r = {1'b1, {(OFF_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(OFF_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

[rtl/safi_if.sv]
// Valid/ready channel interfaces for the sprite animation frame index block.
// Depends on safi_pkg for the payload widths.
interface safi_req_if import safi_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [STEP_W-1:0]  step;
    logic [RND_W-1:0]   random_fraction;
    logic               sprite_loaded;

    modport source (output valid, kind, step, random_fraction, sprite_loaded, input ready);
    modport sink   (input valid, kind, step, random_fraction, sprite_loaded, output ready);
endinterface

interface safi_rsp_if import safi_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FRAME_W-1:0] frame;
    logic               updated;

    modport source (output valid, frame, updated, input ready);
    modport sink   (input valid, frame, updated, output ready);
endinterface

[rtl/sprite_animation_frame_index_top.sv]
// Sprite animation frame index: turns a time step into a fractional frame index.
// Pause and ignored requests go straight to the result; queries pass setup, the multiplies and
// the sum, and with repeat mode the 2-bit-per-cycle modulo, before the result is registered.
// One request at a time; the next request is taken the cycle after the result is registered.
// rst_n asynchronously loads the reset values of the control and config registers only.
// Depends on safi_pkg and safi_if.
module sprite_animation_frame_index_top
    import safi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    safi_req_if.sink              req,
    safi_rsp_if.source            rsp
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SETUP = 4'd1;
    localparam logic [3:0] S_RMUL  = 4'd2;
    localparam logic [3:0] S_RADD  = 4'd3;
    localparam logic [3:0] S_PMUL  = 4'd4;
    localparam logic [3:0] S_ZADJ  = 4'd5;
    localparam logic [3:0] S_SUM   = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_POST  = 4'd8;
    localparam logic [3:0] S_RES   = 4'd9;

    logic [3:0]          state_reg, state_next;
    logic [FC_W-1:0]     frame_count_reg, frame_count_next;
    logic [RATE_W-1:0]   frame_rate_reg, frame_rate_next;
    logic [DELAY_W-1:0]  delay_frames_reg, delay_frames_next;
    logic                repeat_mode_reg, repeat_mode_next;
    logic                rewind_mode_reg, rewind_mode_next;
    offset_t             offset_now_reg, offset_now_next;
    logic                random_pending_reg, random_pending_next;
    logic                zero_pending_reg, zero_pending_next;
    logic                zero_act_reg, zero_act_next;
    logic [CSTEP_W-1:0]  cached_step_reg, cached_step_next;
    logic [FRAME_W-1:0]  cached_frame_reg, cached_frame_next;
    logic [PAUSE_W-1:0]  pause_count_reg, pause_count_next;
    logic                out_valid_reg, out_valid_next;

    logic [STEP_W-1:0]   s_reg, s_next;
    logic [RND_W-1:0]    rnd_reg, rnd_next;
    logic [LAST_W-1:0]   last_reg, last_next;
    logic [FPOS_W-1:0]   fpos_reg, fpos_next;
    logic [CYC_W-1:0]    cycle_reg, cycle_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [DIV_W-1:0]    f_reg, f_next;
    logic [CYC_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [FRAME_W-1:0]  res_frame_reg, res_frame_next;
    logic                res_upd_reg, res_upd_next;
    logic [FRAME_W-1:0]  out_frame_reg, out_frame_next;
    logic                out_upd_reg, out_upd_next;

    logic [STEP_W-1:0]   mul_a;
    logic [RATE_W-1:0]   mul_b;
    logic [PROD_W-1:0]   mul_p;

    logic                req_fire;
    logic [CSTEP_W-1:0]  s_full;
    logic                ignore;
    logic [FC_W-1:0]     frames;
    logic [LAST_W-1:0]   last_c;
    logic [FPOS_W-1:0]   fpos_c;
    wide_t               wide_sum;
    logic [CYC_W:0]      r1;
    logic [CYC_W:0]      r2;
    logic [CYC_W-1:0]    rem1;
    logic [CYC_W-1:0]    rem2;
    wide_t               refl;
    logic [DIV_W-1:0]    fv;

    assign req.ready   = (state_reg == S_IDLE);
    assign req_fire    = req.valid && req.ready;
    assign rsp.valid   = out_valid_reg;
    assign rsp.frame   = out_frame_reg;
    assign rsp.updated = out_upd_reg;

    assign mul_a = (state_reg == S_RMUL) ? STEP_W'(cycle_reg) : s_reg;
    assign mul_b = (state_reg == S_RMUL) ? RATE_W'(rnd_reg) : frame_rate_reg;
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign s_full = CSTEP_W'(req.step) - CSTEP_W'(pause_count_reg);
    assign ignore = s_full[CSTEP_W-1] || (s_full == cached_step_reg) || !req.sprite_loaded;
    assign frames = (frame_count_reg > FC_W'(MAX_FRAMES)) ? FC_W'(MAX_FRAMES) : frame_count_reg;
    assign last_c = {LAST_W'(frames - FC_W'(1))} << FRAC_BITS;
    assign fpos_c = FPOS_W'(frames) << FRAC_BITS;

    always_comb
    begin
        state_next          = state_reg;
        frame_count_next    = frame_count_reg;
        frame_rate_next     = frame_rate_reg;
        delay_frames_next   = delay_frames_reg;
        repeat_mode_next    = repeat_mode_reg;
        rewind_mode_next    = rewind_mode_reg;
        offset_now_next     = offset_now_reg;
        random_pending_next = random_pending_reg;
        zero_pending_next   = zero_pending_reg;
        zero_act_next       = zero_act_reg;
        cached_step_next    = cached_step_reg;
        cached_frame_next   = cached_frame_reg;
        pause_count_next    = pause_count_reg;
        out_valid_next      = out_valid_reg;
        s_next              = s_reg;
        rnd_next            = rnd_reg;
        last_next           = last_reg;
        fpos_next           = fpos_reg;
        cycle_next          = cycle_reg;
        prod_next           = prod_reg;
        f_next              = f_reg;
        rem_next            = rem_reg;
        cnt_next            = cnt_reg;
        res_frame_next      = res_frame_reg;
        res_upd_next        = res_upd_reg;
        out_frame_next      = out_frame_reg;
        out_upd_next        = out_upd_reg;
        wide_sum            = '0;
        r1                  = '0;
        r2                  = '0;
        rem1                = '0;
        rem2                = '0;
        refl                = '0;
        fv                  = f_reg;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    res_frame_next = cached_frame_reg;
                    res_upd_next   = 1'b0;
                    s_next         = s_full[STEP_W-1:0];
                    rnd_next       = req.random_fraction;
                    if (req.kind)
                    begin
                        if (pause_count_reg != '1)
                        begin
                            pause_count_next = pause_count_reg + PAUSE_W'(1);
                        end
                        state_next = S_RES;
                    end
                    else if (ignore)
                    begin
                        state_next = S_RES;
                    end
                    else
                    begin
                        cached_step_next = s_full;
                        state_next       = S_SETUP;
                    end
                end
            end
            S_SETUP:
            begin
                if (frames <= FC_W'(1))
                begin
                    cached_frame_next = '0;
                    res_frame_next    = '0;
                    res_upd_next      = 1'b1;
                    state_next        = S_RES;
                end
                else
                begin
                    last_next  = last_c;
                    fpos_next  = fpos_c;
                    cycle_next = rewind_mode_reg
                        ? CYC_W'({last_c, 1'b0}) + CYC_W'(delay_frames_reg)
                        : CYC_W'(fpos_c) + CYC_W'(delay_frames_reg);
                    zero_act_next = !random_pending_reg && zero_pending_reg;
                    state_next    = random_pending_reg ? S_RMUL : S_PMUL;
                end
            end
            S_RMUL:
            begin
                prod_next           = mul_p;
                random_pending_next = 1'b0;
                state_next          = S_RADD;
            end
            S_RADD:
            begin
                wide_sum = SUM_W'(offset_now_reg)
                    + $signed(SUM_W'(prod_next[CYC_W+FRAC_BITS-1:FRAC_BITS]));
                offset_now_next = sat_off(wide_sum);
                state_next      = S_PMUL;
            end
            S_PMUL:
            begin
                prod_next  = mul_p;
                state_next = zero_act_reg ? S_ZADJ : S_SUM;
            end
            S_ZADJ:
            begin
                wide_sum          = SUM_W'(offset_now_reg) - $signed(SUM_W'(prod_reg));
                offset_now_next   = sat_off(wide_sum);
                zero_pending_next = 1'b0;
                state_next        = S_SUM;
            end
            S_SUM:
            begin
                wide_sum = $signed(SUM_W'(prod_reg)) + SUM_W'(offset_now_reg);
                f_next   = wide_sum[SUM_W-1] ? '0 : wide_sum[DIV_W-1:0];
                rem_next = '0;
                cnt_next = CNT_W'(DIV_STEPS - 1);
                state_next = repeat_mode_reg ? S_DIV : S_POST;
            end
            S_DIV:
            begin
                r1 = {rem_reg, f_reg[DIV_W-1]};
                if (r1 >= {1'b0, cycle_reg})
                begin
                    r1 = r1 - {1'b0, cycle_reg};
                end
                rem1 = r1[CYC_W-1:0];
                r2 = {rem1, f_reg[DIV_W-2]};
                if (r2 >= {1'b0, cycle_reg})
                begin
                    r2 = r2 - {1'b0, cycle_reg};
                end
                rem2     = r2[CYC_W-1:0];
                rem_next = rem2;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    f_next     = DIV_W'(rem2);
                    state_next = S_POST;
                end
                else
                begin
                    f_next = {f_reg[DIV_W-3:0], 2'b00};
                end
            end
            S_POST:
            begin
                fv = f_reg;
                if (!rewind_mode_reg)
                begin
                    if (!repeat_mode_reg)
                    begin
                        if (fv > DIV_W'(last_reg))
                        begin
                            fv = DIV_W'(last_reg);
                        end
                    end
                    else if (fv >= DIV_W'(fpos_reg))
                    begin
                        fv = '0;
                    end
                end
                else if (fv >= DIV_W'(last_reg))
                begin
                    refl = $signed(SUM_W'({last_reg, 1'b0})) - $signed(SUM_W'(fv));
                    fv   = refl[SUM_W-1] ? '0 : refl[DIV_W-1:0];
                end
                if (fv[DIV_W-1:FRAME_W] != '0)
                begin
                    fv = DIV_W'({FRAME_W{1'b1}});
                end
                cached_frame_next = fv[FRAME_W-1:0];
                res_frame_next    = fv[FRAME_W-1:0];
                res_upd_next      = 1'b1;
                state_next        = S_RES;
            end
            S_RES:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_frame_next = res_frame_reg;
                    out_upd_next   = res_upd_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_FRAME_COUNT:   frame_count_next    = cfg_data[FC_W-1:0];
                REG_FRAME_RATE:    frame_rate_next     = cfg_data[RATE_W-1:0];
                REG_DELAY_FRAMES:  delay_frames_next   = cfg_data[DELAY_W-1:0];
                REG_REPEAT_MODE:   repeat_mode_next    = cfg_data[0];
                REG_REWIND_MODE:   rewind_mode_next    = cfg_data[0];
                REG_START_OFFSET:  offset_now_next     = OFF_W'($signed(cfg_data[START_W-1:0]));
                REG_RANDOM_START:  random_pending_next = cfg_data[0];
                REG_START_AT_ZERO: zero_pending_next   = cfg_data[0];
                default:           frame_count_next    = frame_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            frame_count_reg    <= FC_W'(1);
            frame_rate_reg     <= '0;
            delay_frames_reg   <= '0;
            repeat_mode_reg    <= 1'b1;
            rewind_mode_reg    <= 1'b0;
            offset_now_reg     <= '0;
            random_pending_reg <= 1'b1;
            zero_pending_reg   <= 1'b0;
            zero_act_reg       <= 1'b0;
            cached_step_reg    <= '1;
            cached_frame_reg   <= '0;
            pause_count_reg    <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            frame_count_reg    <= frame_count_next;
            frame_rate_reg     <= frame_rate_next;
            delay_frames_reg   <= delay_frames_next;
            repeat_mode_reg    <= repeat_mode_next;
            rewind_mode_reg    <= rewind_mode_next;
            offset_now_reg     <= offset_now_next;
            random_pending_reg <= random_pending_next;
            zero_pending_reg   <= zero_pending_next;
            zero_act_reg       <= zero_act_next;
            cached_step_reg    <= cached_step_next;
            cached_frame_reg   <= cached_frame_next;
            pause_count_reg    <= pause_count_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg         <= s_next;
        rnd_reg       <= rnd_next;
        last_reg      <= last_next;
        fpos_reg      <= fpos_next;
        cycle_reg     <= cycle_next;
        prod_reg      <= prod_next;
        f_reg         <= f_next;
        rem_reg       <= rem_next;
        cnt_reg       <= cnt_next;
        res_frame_reg <= res_frame_next;
        res_upd_reg   <= res_upd_next;
        out_frame_reg <= out_frame_next;
        out_upd_reg   <= out_upd_next;
    end

    // The running remainder of the modulo always stays below the cycle length.
    a_rem_below_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < cycle_reg)
        else $error("modulo remainder not below cycle length");

    // A pause transaction never lowers the pause count.
    a_pause_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req.kind) |=> pause_count_reg >= $past(pause_count_reg))
        else $error("pause count decreased");

    // A finished result with a free output slot is presented in the next cycle.
    a_result_issued: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RES && (!out_valid_reg || rsp.ready))
        |=> (state_reg == S_IDLE && out_valid_reg))
        else $error("finished result not presented");

endmodule

[verif/sprite_animation_frame_index_top_test.sv]
// Self-checking testbench for sprite_animation_frame_index_top.
// Drives request transactions and register writes, predicts every frame result and checks each
// response transaction. Depends on safi_pkg, safi_if and the block itself.
module sprite_animation_frame_index_top_test;
    import safi_pkg::*;

    localparam logic   KIND_QUERY  = 1'b0;
    localparam logic   KIND_PAUSE  = 1'b1;
    localparam int     PAUSE_MAX   = 65535;
    localparam longint OFFSET_HI   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint OFFSET_LO   = -OFFSET_HI - 1;
    localparam longint FRAME_HI    = 64'sh0000_0000_3FFF_FFFF;
    localparam int     CYCLE_LIMIT = 1500000;
    localparam int     MAX_REPORTS = 10;

    typedef struct packed {
        logic              kind;
        logic [STEP_W-1:0] step;
        logic [RND_W-1:0]  random_fraction;
        logic              sprite_loaded;
    } frame_query_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               updated;
    } frame_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    safi_req_if req_ch();
    safi_rsp_if rsp_ch();

    sprite_animation_frame_index_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    logic [FC_W-1:0]    frame_count_reg;
    logic [RATE_W-1:0]  frame_rate_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic               repeat_reg;
    logic               rewind_reg;

    longint last_step;
    longint shown_frame;
    longint frame_offset;
    logic   random_armed;
    logic   zero_armed;
    int     paused_steps;

    frame_result_t pending_frames[$];
    int            mismatches;
    int            results_seen;
    int            cycle_count;
    int            burst_left;
    int            hold_left;
    bit            no_gaps;
    bit            rsp_fast;

    always #1 clk = ~clk;

    function automatic longint clamp_offset(input longint v);
        longint r;
        r = v;
        if (v > OFFSET_HI)
        begin
            r = OFFSET_HI;
        end
        else if (v < OFFSET_LO)
        begin
            r = OFFSET_LO;
        end
        return r;
    endfunction

    function automatic frame_result_t predict_frame(input frame_query_t q);
        frame_result_t r;
        longint s;
        longint frames;
        longint last;
        longint span;
        longint cycle;
        longint f;
        r.frame   = shown_frame[FRAME_W-1:0];
        r.updated = 1'b0;
        if (q.kind == KIND_PAUSE)
        begin
            if (paused_steps < PAUSE_MAX)
            begin
                paused_steps++;
            end
            return r;
        end
        s = longint'(q.step) - longint'(paused_steps);
        if (s < 0 || s == last_step || !q.sprite_loaded)
        begin
            return r;
        end
        last_step = s;
        frames = longint'(frame_count_reg);
        if (frames > MAX_FRAMES)
        begin
            frames = longint'(MAX_FRAMES);
        end
        if (frames <= 1)
        begin
            shown_frame = 0;
            r.frame     = '0;
            r.updated   = 1'b1;
            return r;
        end
        last  = (frames - 1) << FRAC_BITS;
        span  = frames << FRAC_BITS;
        cycle = (rewind_reg ? 2 * last : span) + longint'(delay_reg);
        if (random_armed)
        begin
            random_armed = 1'b0;
            frame_offset = clamp_offset(frame_offset +
                ((cycle * longint'(q.random_fraction)) >> RND_W));
        end
        else if (zero_armed)
        begin
            zero_armed   = 1'b0;
            frame_offset = clamp_offset(frame_offset - longint'(frame_rate_reg) * s);
        end
        f = longint'(frame_rate_reg) * s + frame_offset;
        if (f < 0)
        begin
            f = 0;
        end
        if (repeat_reg)
        begin
            f = f % cycle;
        end
        if (!rewind_reg)
        begin
            if (!repeat_reg)
            begin
                if (f > last)
                begin
                    f = last;
                end
            end
            else if (f >= span)
            begin
                f = 0;
            end
        end
        else if (f >= last)
        begin
            f = 2 * last - f;
            if (f < 0)
            begin
                f = 0;
            end
        end
        if (f > FRAME_HI)
        begin
            f = FRAME_HI;
        end
        shown_frame = f;
        r.frame     = f[FRAME_W-1:0];
        r.updated   = 1'b1;
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_FRAME_COUNT:   frame_count_reg = val[FC_W-1:0];
            REG_FRAME_RATE:    frame_rate_reg  = val[RATE_W-1:0];
            REG_DELAY_FRAMES:  delay_reg       = val[DELAY_W-1:0];
            REG_REPEAT_MODE:   repeat_reg      = val[0];
            REG_REWIND_MODE:   rewind_reg      = val[0];
            REG_START_OFFSET:  frame_offset    = longint'($signed(val[START_W-1:0]));
            REG_RANDOM_START:  random_armed    = val[0];
            REG_START_AT_ZERO: zero_armed      = val[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_request(input logic kind, input logic [STEP_W-1:0] step,
                                input logic [RND_W-1:0] rnd, input logic loaded);
        int gap;
        frame_query_t q;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        q.kind            = kind;
        q.step            = step;
        q.random_fraction = rnd;
        q.sprite_loaded   = loaded;
        req_ch.valid           <= 1'b1;
        req_ch.kind            <= kind;
        req_ch.step            <= step;
        req_ch.random_fraction <= rnd;
        req_ch.sprite_loaded   <= loaded;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        pending_frames.push_back(predict_frame(q));
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (pending_frames.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    task automatic test_single_frame();
        send_request(KIND_QUERY, 31'd0, 16'hFFFF, 1'b1);
        send_request(KIND_QUERY, 31'd0, 16'h0000, 1'b1);
        send_request(KIND_QUERY, 31'd9, 16'h1234, 1'b0);
    endtask

    task automatic test_random_start();
        wait_idle();
        write_reg(REG_FRAME_COUNT, 32'd4096);
        write_reg(REG_FRAME_RATE, 32'h0001_0000);
        write_reg(REG_DELAY_FRAMES, 32'h0FFF_FFFF);
        write_reg(REG_REPEAT_MODE, 32'd1);
        write_reg(REG_REWIND_MODE, 32'd0);
        write_reg(REG_RANDOM_START, 32'd1);
        send_request(KIND_QUERY, 31'd10, 16'hFFFF, 1'b1);
        send_request(KIND_QUERY, 31'd11, 16'h0000, 1'b1);
        send_request(KIND_PAUSE, 31'h7FFF_FFFF, 16'hFFFF, 1'b1);
        send_request(KIND_QUERY, 31'd11, 16'h8000, 1'b1);
        send_request(KIND_QUERY, 31'd0, 16'h8000, 1'b1);
    endtask

    task automatic test_start_at_zero();
        wait_idle();
        write_reg(REG_RANDOM_START, 32'd0);
        write_reg(REG_START_AT_ZERO, 32'd1);
        write_reg(REG_START_OFFSET, 32'h7FFF_FFFF);
        write_reg(REG_FRAME_RATE, 32'h00FF_FFFF);
        write_reg(REG_FRAME_COUNT, 32'd8191);
        write_reg(REG_REPEAT_MODE, 32'd0);
        write_reg(REG_REWIND_MODE, 32'd1);
        send_request(KIND_QUERY, 31'h7FFF_FFFF, 16'h0000, 1'b1);
        send_request(KIND_QUERY, 31'h7FFF_FFF0, 16'hFFFF, 1'b1);
        send_request(KIND_QUERY, 31'd3, 16'h0000, 1'b1);
    endtask

    task automatic test_play_once();
        wait_idle();
        write_reg(REG_START_OFFSET, 32'hFFFE_0000);
        write_reg(REG_START_AT_ZERO, 32'd0);
        write_reg(REG_FRAME_COUNT, 32'd3);
        write_reg(REG_FRAME_RATE, 32'h0000_8000);
        write_reg(REG_DELAY_FRAMES, 32'd0);
        write_reg(REG_REWIND_MODE, 32'd0);
        send_request(KIND_QUERY, 31'd1, 16'h0000, 1'b1);
        send_request(KIND_QUERY, 31'd4, 16'h0000, 1'b1);
        send_request(KIND_QUERY, 31'd6, 16'h0000, 1'b1);
        send_request(KIND_QUERY, 31'd20, 16'h0000, 1'b1);
    endtask

    task automatic test_repeat_delay();
        wait_idle();
        write_reg(REG_START_OFFSET, 32'd0);
        write_reg(REG_FRAME_COUNT, 32'd4);
        write_reg(REG_FRAME_RATE, 32'h0001_0000);
        write_reg(REG_DELAY_FRAMES, 32'h0002_0000);
        write_reg(REG_REPEAT_MODE, 32'd1);
        for (int i = 104; i < 108; i++)
        begin
            send_request(KIND_QUERY, STEP_W'(i), 16'h0000, 1'b1);
        end
    endtask

    task automatic test_rewind();
        wait_idle();
        write_reg(REG_REWIND_MODE, 32'd1);
        write_reg(REG_DELAY_FRAMES, 32'h0001_0000);
        for (int i = 200; i < 204; i++)
        begin
            send_request(KIND_QUERY, STEP_W'(i), 16'h0000, 1'b1);
        end
    endtask

    task automatic test_zero_frames();
        wait_idle();
        write_reg(REG_FRAME_COUNT, 32'd0);
        send_request(KIND_QUERY, 31'd300, 16'h0000, 1'b1);
    endtask

    task automatic randomize_config(input int ph);
        logic [CFG_DATA_W-1:0] fc;
        logic [CFG_DATA_W-1:0] rate;
        logic [CFG_DATA_W-1:0] dly;
        logic [CFG_DATA_W-1:0] off;
        logic [3:0]            flags;
        case ($urandom_range(0, 5))
            0:       fc = $urandom_range(2, 8);
            1:       fc = $urandom_range(2, 4096);
            2:       fc = 4096;
            3:       fc = $urandom_range(4097, 8191);
            4:       fc = 1;
            default: fc = $urandom_range(2, 64);
        endcase
        case ($urandom_range(0, 2))
            0:       rate = $urandom_range(0, 32'h0002_0000);
            1:       rate = $urandom() & 32'h00FF_FFFF;
            default: rate = $urandom_range(32'h0000_4000, 32'h0003_0000);
        endcase
        case ($urandom_range(0, 2))
            0:       dly = 0;
            1:       dly = $urandom_range(0, 32'h0004_0000);
            default: dly = $urandom() & 32'h0FFF_FFFF;
        endcase
        case ($urandom_range(0, 2))
            0:       off = 0;
            1:       off = $urandom();
            default: off = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
        flags = 4'($urandom());
        if (ph == 0)
        begin
            fc    = 0;
            rate  = 0;
            dly   = 0;
            off   = 32'h8000_0000;
            flags = 4'b0000;
        end
        else if (ph == 1)
        begin
            fc    = 8191;
            rate  = 32'h00FF_FFFF;
            dly   = 32'h0FFF_FFFF;
            off   = 32'h7FFF_FFFF;
            flags = 4'b1111;
        end
        write_reg(REG_FRAME_COUNT, fc);
        write_reg(REG_FRAME_RATE, rate);
        write_reg(REG_DELAY_FRAMES, dly);
        write_reg(REG_REPEAT_MODE, CFG_DATA_W'(flags[0]));
        write_reg(REG_REWIND_MODE, CFG_DATA_W'(flags[1]));
        write_reg(REG_START_OFFSET, off);
        write_reg(REG_RANDOM_START, CFG_DATA_W'(flags[2]));
        write_reg(REG_START_AT_ZERO, CFG_DATA_W'(flags[3]));
    endtask

    task automatic test_random_phases();
        logic [STEP_W-1:0] t;
        int n;
        int pick;
        for (int ph = 0; ph < 14; ph++)
        begin
            wait_idle();
            randomize_config(ph);
            t = ($urandom_range(0, 3) == 0) ? STEP_W'($urandom())
                                            : STEP_W'($urandom_range(0, 1000));
            n = $urandom_range(25, 45);
            for (int i = 0; i < n; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                begin
                    send_request(KIND_PAUSE, STEP_W'($urandom()), RND_W'($urandom()),
                                 1'($urandom_range(0, 1)));
                end
                else if (pick < 14)
                begin
                    send_request(KIND_QUERY, STEP_W'($urandom()), RND_W'($urandom()), 1'b1);
                end
                else if (pick < 18)
                begin
                    send_request(KIND_QUERY, t, RND_W'($urandom()), 1'b0);
                end
                else
                begin
                    t = t + STEP_W'($urandom_range(0, 3));
                    send_request(KIND_QUERY, t, RND_W'($urandom()), 1'b1);
                end
            end
        end
    endtask

    task automatic test_receiver_hold();
        wait_idle();
        write_reg(REG_FRAME_COUNT, 32'd8);
        write_reg(REG_FRAME_RATE, 32'h0000_3000);
        write_reg(REG_REPEAT_MODE, 32'd1);
        no_gaps   = 1'b1;
        hold_left = 400;
        for (int i = 0; i < 12; i++)
        begin
            send_request(KIND_QUERY, STEP_W'(5000 + i), RND_W'($urandom()), 1'b1);
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_pause_burst();
        wait_idle();
        write_reg(REG_FRAME_COUNT, 32'd16);
        write_reg(REG_FRAME_RATE, 32'h0001_0000);
        write_reg(REG_DELAY_FRAMES, 32'd0);
        write_reg(REG_REWIND_MODE, 32'd0);
        no_gaps  = 1'b1;
        rsp_fast = 1'b1;
        for (int i = 0; i < 24; i++)
        begin
            send_request(KIND_PAUSE, STEP_W'($urandom()), RND_W'($urandom()),
                         1'($urandom_range(0, 1)));
        end
        no_gaps  = 1'b0;
        rsp_fast = 1'b0;
        send_request(KIND_QUERY, 31'd100, 16'h0000, 1'b1);
        send_request(KIND_QUERY, STEP_W'(PAUSE_MAX + 7), 16'h0000, 1'b1);
        send_request(KIND_QUERY, STEP_W'(PAUSE_MAX + 8), 16'h0000, 1'b1);
        send_request(KIND_QUERY, 31'h7FFF_FFFF, 16'h0000, 1'b1);
    endtask

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("sprite_animation_frame_index_top_test: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        frame_result_t want;
        int tick;
        rsp_ch.ready = 1'b0;
        tick = 0;
        forever
        begin
            @(posedge clk);
            // Each response transaction is matched against the oldest expected frame.
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                if (pending_frames.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("unexpected response transaction: frame %h updated %b",
                                 rsp_ch.frame, rsp_ch.updated);
                    end
                end
                else
                begin
                    want = pending_frames.pop_front();
                    if (rsp_ch.frame !== want.frame || rsp_ch.updated !== want.updated)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("result %0d: expected %h/%b, got %h/%b",
                                     results_seen, want.frame, want.updated,
                                     rsp_ch.frame, rsp_ch.updated);
                        end
                    end
                end
            end
            tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (rsp_fast)
            begin
                rsp_ch.ready <= 1'b1;
            end
            else
            begin
                case ((tick / 97) % 4)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= ($urandom_range(0, 2) == 0);
                    2:       rsp_ch.ready <= (tick % 5 > 1);
                    default: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial
    begin
        rst_n                  = 1'b0;
        cfg_wr_en              = 1'b0;
        cfg_index              = '0;
        cfg_data               = '0;
        req_ch.valid           = 1'b0;
        req_ch.kind            = KIND_QUERY;
        req_ch.step            = '0;
        req_ch.random_fraction = '0;
        req_ch.sprite_loaded   = 1'b0;
        frame_count_reg        = FC_W'(1);
        frame_rate_reg         = '0;
        delay_reg              = '0;
        repeat_reg             = 1'b1;
        rewind_reg             = 1'b0;
        last_step              = -1;
        shown_frame            = 0;
        frame_offset           = 0;
        random_armed           = 1'b1;
        zero_armed             = 1'b0;
        paused_steps           = 0;
        mismatches             = 0;
        results_seen           = 0;
        burst_left             = 0;
        hold_left              = 0;
        no_gaps                = 1'b0;
        rsp_fast               = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_frame();
        test_random_start();
        test_start_at_zero();
        test_play_once();
        test_repeat_delay();
        test_rewind();
        test_zero_frames();
        test_random_phases();
        test_receiver_hold();
        test_pause_burst();
        wait_idle();
        repeat (50) @(posedge clk);
        if (pending_frames.size() != 0)
        begin
            mismatches++;
        end
        if (mismatches == 0)
        begin
            $display("sprite_animation_frame_index_top_test: done, clean");
        end
        else
        begin
            $display("sprite_animation_frame_index_top_test: done, errors");
        end
        $finish;
    end

endmodule

[files.f]
rtl/safi_pkg.sv
rtl/safi_if.sv
rtl/sprite_animation_frame_index_top.sv
verif/sprite_animation_frame_index_top_test.sv
